// ===== design/page_table_walker_x86_64_assert.svh =====
// Assertion macros shared by the walker RTL
`ifndef PAGE_TABLE_WALKER_X86_64_ASSERT_SVH
`define PAGE_TABLE_WALKER_X86_64_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define PTW_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define PTW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/ptw_pkg.sv =====
package ptw_pkg;

	localparam int PHYS_ADDR_BITS = 52;
	localparam int PA_W = 52;
	localparam int VA_W = 48;
	localparam int ENTRY_W = 64;
	localparam int OFS_W = 30;

	localparam logic [PA_W-1:0] PHYS_MASK = {PA_W{1'b1}} >> (PA_W - PHYS_ADDR_BITS);

	localparam logic OP_TRANSLATE = 1'b0;
	localparam logic OP_ENTRY = 1'b1;

	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	localparam logic [1:0] SIZE_4K = 2'd0;
	localparam logic [1:0] SIZE_2M = 2'd1;
	localparam logic [1:0] SIZE_1G = 2'd2;

	localparam logic [1:0] LVL_PML4 = 2'd0;
	localparam logic [1:0] LVL_PDPT = 2'd1;
	localparam logic [1:0] LVL_PD = 2'd2;
	localparam logic [1:0] LVL_PT = 2'd3;

	localparam int BIT_PRESENT = 0;
	localparam int BIT_LARGE = 7;

	// Classified work handed from front to back: address = base + offset
	typedef struct packed {
		logic             kind;
		logic [PA_W-1:0]  base;
		logic [OFS_W-1:0] offset;
		logic             fault;
		logic [1:0]       page_size;
		logic [1:0]       fault_level;
	} ptw_cmd_t;

	typedef struct packed {
		logic       busy;
		logic [1:0] level;
	} ptw_stat_t;

	// Table index of a virtual address at a given level
	function automatic logic [8:0] level_index(input logic [VA_W-1:0] va,
		input logic [1:0] level);
		logic [8:0] idx;
		case (level)
			LVL_PML4: idx = va[47:39];
			LVL_PDPT: idx = va[38:30];
			LVL_PD:   idx = va[29:21];
			LVL_PT:   idx = va[20:12];
			default:  idx = va[47:39];
		endcase
		return idx;
	endfunction

	// Entry offset in a table, as an address offset
	function automatic logic [OFS_W-1:0] index_offset(input logic [8:0] idx);
		return {{(OFS_W-12){1'b0}}, idx, 3'b000};
	endfunction

endpackage

// ===== design/ptw_if.sv =====
interface ptw_item_if;
	import ptw_pkg::*;
	logic               valid;
	logic               ready;
	logic               op;
	logic [VA_W-1:0]    virt_addr;
	logic [PA_W-1:0]    table_base;
	logic [ENTRY_W-1:0] entry_data;

	modport source (output valid, op, virt_addr, table_base, entry_data, input ready);
	modport sink (input valid, op, virt_addr, table_base, entry_data, output ready);
endinterface

interface ptw_result_if;
	import ptw_pkg::*;
	logic            valid;
	logic            ready;
	logic            kind;
	logic [PA_W-1:0] read_address;
	logic [PA_W-1:0] phys_addr;
	logic            fault;
	logic [1:0]      page_size;
	logic [1:0]      fault_level;

	modport source (output valid, kind, read_address, phys_addr, fault, page_size,
		fault_level, input ready);
	modport sink (input valid, kind, read_address, phys_addr, fault, page_size,
		fault_level, output ready);
endinterface

interface ptw_cfg_if;
	import ptw_pkg::*;
	logic            valid;
	logic            ready;
	logic [PA_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== design/page_table_walker_x86_64.sv =====
// Four-level x86-64 page table walker. Each item transaction is either a
// translate request (op 0) or a page table entry returned by memory (op 1);
// the answer is a read request for the next entry or a finished translation
// with fault, page size and fault level. Translates during a walk and entries
// while idle are accepted and dropped without a result. The block accepts one
// transaction per cycle while its two-entry queue has room; front classifies a kept
// transaction into the queue at the accepting edge, and back adds base and offset
// into the output register when it pops the queue. Sustained throughput is one
// result per cycle while the result channel is not stalled, set by the queue pop
// into the output register. Result stalls fill the queue after two transactions
// and then hold off the item channel. The default root table base is written
// through cfg; the user must do so only while the walker is idle, which the
// block itself does not enforce.
`include "page_table_walker_x86_64_assert.svh"

module page_table_walker_x86_64
	import ptw_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	ptw_item_if.sink     item,
	ptw_result_if.source result,
	ptw_cfg_if.sink      cfg
);

	logic      push;
	logic      q_ready;
	logic      pop;
	logic      q_valid;
	ptw_cmd_t  front_cmd;
	ptw_cmd_t  back_cmd;
	ptw_stat_t stat;

	ptw_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.cfg     (cfg),
		.q_ready (q_ready),
		.push    (push),
		.cmd     (front_cmd),
		.stat    (stat)
	);

	ptw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (front_cmd),
		.push_ready (q_ready),
		.pop        (pop),
		.pop_valid  (q_valid),
		.pop_cmd    (back_cmd)
	);

	ptw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (back_cmd),
		.pop       (pop),
		.result    (result)
	);

	// Check walk bookkeeping
	`PTW_ASSERT_NEXT(a_done_goes_idle, push && front_cmd.kind == KIND_DONE, !stat.busy,
		"walker still busy after a finished walk")
	`PTW_ASSERT_NOW(a_idle_level_zero, !stat.busy, stat.level == LVL_PML4,
		"walk level nonzero while idle")
	`PTW_ASSERT_NOW(a_fault_zero_addr, push && front_cmd.fault,
		front_cmd.base == '0 && front_cmd.offset == '0 && front_cmd.page_size == SIZE_4K,
		"fault command carries a nonzero address or size")

endmodule

// ===== design/ptw_front.sv =====
module ptw_front
	import ptw_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	ptw_item_if.sink     item,
	ptw_cfg_if.sink      cfg,
	input  logic         q_ready,
	output logic         push,
	output ptw_cmd_t     cmd,
	output ptw_stat_t    stat
);

	logic            busy_q;
	logic [1:0]      level_q;
	logic [VA_W-1:0] va_q;
	logic [PA_W-1:0] default_base_q;

	logic            accept;
	logic            keep;
	logic            done;
	logic [PA_W-1:0] root_base;
	logic [PA_W-1:0] frame;
	logic [1:0]      next_level;
	logic [ENTRY_W-1:0] e;

	assign item.ready = q_ready;
	assign cfg.ready = 1'b1;
	assign accept = item.valid && item.ready;
	assign e = item.entry_data;
	assign stat = '{busy: busy_q, level: level_q};

	// Hold the default root table base
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_base_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			default_base_q <= cfg.data;
		end
	end

	// Classify the transaction against the walk state
	always_comb begin
		root_base = (item.table_base == '0) ? default_base_q : item.table_base;
		frame = {e[51:12], 12'b0} & PHYS_MASK;
		next_level = level_q + 2'd1;
		keep = 1'b0;
		done = 1'b0;
		cmd = '0;
		if (item.op == OP_TRANSLATE) begin
			keep = !busy_q;
			cmd.kind = KIND_READ;
			cmd.base = root_base;
			cmd.offset = index_offset(level_index(item.virt_addr, LVL_PML4));
		end else begin
			keep = busy_q;
			done = 1'b1;
			cmd.kind = KIND_DONE;
			if (!e[BIT_PRESENT]) begin
				cmd.fault = 1'b1;
				cmd.fault_level = level_q;
			end else if (level_q == LVL_PDPT && e[BIT_LARGE]) begin
				cmd.base = {e[51:30], 30'b0} & PHYS_MASK;
				cmd.offset = va_q[29:0];
				cmd.page_size = SIZE_1G;
			end else if (level_q == LVL_PD && e[BIT_LARGE]) begin
				cmd.base = {e[51:21], 21'b0} & PHYS_MASK;
				cmd.offset = {9'b0, va_q[20:0]};
				cmd.page_size = SIZE_2M;
			end else if (level_q == LVL_PT) begin
				cmd.base = frame;
				cmd.offset = {18'b0, va_q[11:0]};
				cmd.page_size = SIZE_4K;
			end else begin
				done = 1'b0;
				cmd.kind = KIND_READ;
				cmd.base = frame;
				cmd.offset = index_offset(level_index(va_q, next_level));
			end
		end
		push = accept && keep;
	end

	// Advance the walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			level_q <= LVL_PML4;
			va_q <= '0;
		end else if (push) begin
			if (item.op == OP_TRANSLATE) begin
				busy_q <= 1'b1;
				level_q <= LVL_PML4;
				va_q <= item.virt_addr;
			end else if (done) begin
				busy_q <= 1'b0;
				level_q <= LVL_PML4;
			end else begin
				level_q <= next_level;
			end
		end
	end

endmodule

// ===== design/ptw_queue.sv =====
module ptw_queue
	import ptw_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  ptw_cmd_t push_cmd,
	output logic     push_ready,
	input  logic     pop,
	output logic     pop_valid,
	output ptw_cmd_t pop_cmd
);

	ptw_cmd_t   mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_cmd = mem_q[rd_ptr_q];

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/ptw_back.sv =====
module ptw_back
	import ptw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  ptw_cmd_t    cmd,
	output logic        pop,
	ptw_result_if.source result
);

	logic            out_valid_q;
	logic            kind_q;
	logic [PA_W-1:0] addr_q;
	logic            fault_q;
	logic [1:0]      page_size_q;
	logic [1:0]      fault_level_q;
	logic [PA_W-1:0] sum;

	assign pop = cmd_valid && (!out_valid_q || result.ready);
	assign sum = (cmd.base + {{(PA_W-OFS_W){1'b0}}, cmd.offset}) & PHYS_MASK;

	// Hold the result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q <= cmd.kind;
			addr_q <= sum;
			fault_q <= cmd.fault;
			page_size_q <= cmd.page_size;
			fault_level_q <= cmd.fault_level;
		end
	end

	assign result.valid = out_valid_q;
	assign result.kind = kind_q;
	assign result.read_address = (kind_q == KIND_READ) ? addr_q : '0;
	assign result.phys_addr = (kind_q == KIND_DONE) ? addr_q : '0;
	assign result.fault = fault_q;
	assign result.page_size = page_size_q;
	assign result.fault_level = fault_level_q;

endmodule

// ===== bench/tb_page_table_walker_x86_64.sv =====
module tb_page_table_walker_x86_64;
	timeunit 1ns;
	timeprecision 1ps;
	import ptw_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES = 6;
	localparam int WALK_ITEMS_PER_PHASE = 225;
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		logic             kind;
		logic [PA_W-1:0]  read_address;
		logic [PA_W-1:0]  phys_addr;
		logic             fault;
		logic [1:0]       page_size;
		logic [1:0]       fault_level;
	} walk_answer_t;

	// Shadow walker: tracks walk progress and queues the answers it predicts
	class walk_scoreboard;
		logic [PA_W-1:0] default_base;
		logic            busy;
		logic [1:0]      level;
		logic [VA_W-1:0] held_va;
		walk_answer_t    pending[$];
		int              errors;
		int              dropped;
		int              reads;
		int              faults[4];
		int              pages[3];

		function new();
			default_base = '0;
			busy = 1'b0;
			level = LVL_PML4;
			held_va = '0;
		endfunction

		// Byte offset of the table slot that a level indexes
		function logic [PA_W-1:0] slot_offset(logic [VA_W-1:0] va, logic [1:0] lvl);
			logic [8:0] idx;
			idx = 9'(va >> (39 - 9 * lvl));
			return PA_W'(idx) << 3;
		endfunction

		function void note_item(logic op, logic [VA_W-1:0] va, logic [PA_W-1:0] base,
			logic [ENTRY_W-1:0] ent);
			walk_answer_t a;
			a = '0;
			a.kind = KIND_DONE;
			if (op == OP_TRANSLATE) begin
				// Drop a translate that lands mid-walk
				if (busy) begin
					dropped++;
					return;
				end
				held_va = va;
				level = LVL_PML4;
				busy = 1'b1;
				a.kind = KIND_READ;
				a.read_address = ((base == '0) ? default_base : base) + slot_offset(va, LVL_PML4);
			end else begin
				if (!busy) begin
					dropped++;
					return;
				end
				if (!ent[BIT_PRESENT]) begin
					a.fault = 1'b1;
					a.fault_level = level;
				end else if (level == LVL_PDPT && ent[BIT_LARGE]) begin
					a.page_size = SIZE_1G;
					a.phys_addr = {ent[51:30], 30'b0} + PA_W'(held_va[29:0]);
				end else if (level == LVL_PD && ent[BIT_LARGE]) begin
					a.page_size = SIZE_2M;
					a.phys_addr = {ent[51:21], 21'b0} + PA_W'(held_va[20:0]);
				end else if (level == LVL_PT) begin
					a.page_size = SIZE_4K;
					a.phys_addr = {ent[51:12], 12'b0} + PA_W'(held_va[11:0]);
				end else begin
					// Advance one level and request the next entry
					level = level + 2'd1;
					a.kind = KIND_READ;
					a.read_address = {ent[51:12], 12'b0} + slot_offset(held_va, level);
				end
				if (a.kind == KIND_DONE) begin
					busy = 1'b0;
					level = LVL_PML4;
				end
			end
			pending.push_back(a);
		endfunction

		function void check_answer(walk_answer_t got);
			walk_answer_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: kind %0d ra %h pa %h fault %0d size %0d lvl %0d",
						got.kind, got.read_address, got.phys_addr, got.fault,
						got.page_size, got.fault_level);
				return;
			end
			want = pending.pop_front();
			if (want.kind == KIND_READ)
				reads++;
			else if (want.fault)
				faults[want.fault_level]++;
			else
				pages[want.page_size]++;
			if (got.kind !== want.kind || got.read_address !== want.read_address ||
				got.phys_addr !== want.phys_addr || got.fault !== want.fault ||
				got.page_size !== want.page_size || got.fault_level !== want.fault_level) begin
				errors++;
				if (errors <= 10) begin
					$display("result mismatch at %0t", $realtime);
					$display("  expected kind %0d ra %h pa %h fault %0d size %0d lvl %0d",
						want.kind, want.read_address, want.phys_addr, want.fault,
						want.page_size, want.fault_level);
					$display("  actual   kind %0d ra %h pa %h fault %0d size %0d lvl %0d",
						got.kind, got.read_address, got.phys_addr, got.fault,
						got.page_size, got.fault_level);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   calm;
	int   cycles;

	walk_scoreboard sb;

	ptw_item_if   item_ch();
	ptw_result_if result_ch();
	ptw_cfg_if    cfg_ch();

	page_table_walker_x86_64 uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// End the run if the walker stops answering
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("page_table_walker_x86_64: mismatch");
			$finish;
		end
	end

	// Stall the result channel at random, except in the calm phase
	always @(negedge clk) begin
		result_ch.ready <= calm || ($urandom_range(0, 99) >= 29);
	end

	// Check every result transaction against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			sb.check_answer({result_ch.kind, result_ch.read_address,
				result_ch.phys_addr, result_ch.fault, result_ch.page_size,
				result_ch.fault_level});
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Drive one item transaction, with random idle cycles ahead of it
	task automatic send_item(input logic op, input logic [VA_W-1:0] va,
		input logic [PA_W-1:0] base, input logic [ENTRY_W-1:0] ent);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < 29) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.op <= op;
		item_ch.virt_addr <= va;
		item_ch.table_base <= base;
		item_ch.entry_data <= ent;
		item_ch.valid <= 1'b1;
		do @(posedge clk); while (!item_ch.ready);
		sb.note_item(op, va, base, ent);
	endtask

	task automatic send_entry(input logic [ENTRY_W-1:0] ent);
		send_item(OP_ENTRY, VA_W'(rand64()), PA_W'(rand64()), ent);
	endtask

	task automatic send_translate(input logic [VA_W-1:0] va, input logic [PA_W-1:0] base);
		send_item(OP_TRANSLATE, va, base, rand64());
	endtask

	// Hold off until every predicted result is back and the pipeline is quiet
	task automatic drain();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_default_base(input logic [PA_W-1:0] value);
		@(negedge clk);
		cfg_ch.data <= value;
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.default_base = value;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		logic [PA_W-1:0]    base;
		logic [VA_W-1:0]    va;
		logic [ENTRY_W-1:0] ent;
		int                 walk_items;
		int                 roll;

		sb = new();
		calm = 1'b0;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.op = OP_TRANSLATE;
		item_ch.virt_addr = '0;
		item_ch.table_base = '0;
		item_ch.entry_data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_default_base({PA_W{1'b1}});

		// Directed: stray entry while idle, default base with wrap, busy translate,
		// large bit ignored at the top and last levels, 1G and 4K pages
		send_entry(64'h1);
		send_translate({VA_W{1'b1}}, '0);
		send_translate(VA_W'(rand64()), PA_W'(rand64()));
		send_entry({ENTRY_W{1'b1}});
		send_entry(64'hFFFF_FFFF_FFFF_FF81);
		send_translate('0, {PA_W{1'b1}});
		send_entry(64'h1);
		send_entry(64'h1);
		send_entry({ENTRY_W{1'b1}});
		send_translate(VA_W'(rand64()), PA_W'(1));
		send_entry(64'h81);
		send_entry(64'h1);
		send_entry(64'h1);
		send_entry({ENTRY_W{1'b1}});

		// Directed: a fault at each level, reserved bits set on an invalid entry
		send_translate(VA_W'(rand64()), PA_W'(rand64()));
		send_entry(64'hFFFF_FFFF_FFFF_FFFE);
		send_translate(VA_W'(rand64()), '0);
		send_entry(64'h1);
		send_entry(64'h0);
		send_translate(VA_W'(rand64()), PA_W'(rand64()));
		send_entry(64'h1);
		send_entry(64'h1);
		send_entry(64'h80);
		send_translate(VA_W'(rand64()), PA_W'(rand64()));
		send_entry(64'h1);
		send_entry(64'h1);
		send_entry(64'h1);
		send_entry(64'h0);
		drain();

		// Random walks, one default base per phase
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0:       write_default_base('0);
				1:       write_default_base({PA_W{1'b1}});
				3:       write_default_base(PA_W'(1));
				default: write_default_base(PA_W'(rand64()));
			endcase
			calm = (phase == 2);
			walk_items = 0;
			while (walk_items < WALK_ITEMS_PER_PHASE) begin
				roll = $urandom_range(0, 99);
				if (roll < 12) begin
					// Noise: translate mid-walk or entry while idle, both dropped
					if (sb.busy)
						send_translate(VA_W'(rand64()), PA_W'(rand64()));
					else
						send_entry(rand64());
					walk_items++;
				end else if (!sb.busy) begin
					roll = $urandom_range(0, 99);
					if (roll < 10)
						va = {VA_W{1'b1}};
					else if (roll < 15)
						va = '0;
					else
						va = VA_W'(rand64());
					roll = $urandom_range(0, 99);
					if (roll < 25)
						base = '0;
					else if (roll < 32)
						base = {PA_W{1'b1}};
					else if (roll < 38)
						base = PA_W'($urandom_range(1, 4095));
					else
						base = PA_W'(rand64());
					send_translate(va, base);
					walk_items++;
				end else begin
					ent = rand64();
					ent[BIT_PRESENT] = ($urandom_range(0, 99) >= 10);
					if (sb.level == LVL_PDPT || sb.level == LVL_PD)
						ent[BIT_LARGE] = ($urandom_range(0, 99) < 30);
					send_entry(ent);
					walk_items++;
				end
			end
			drain();
		end
		calm = 1'b0;

		$display("walks: %0d entry reads, 4K/2M/1G finishes %0d/%0d/%0d, %0d dropped transactions",
			sb.reads, sb.pages[SIZE_4K], sb.pages[SIZE_2M], sb.pages[SIZE_1G], sb.dropped);
		$display("faults by level: %0d/%0d/%0d/%0d, %0d mismatches",
			sb.faults[LVL_PML4], sb.faults[LVL_PDPT], sb.faults[LVL_PD], sb.faults[LVL_PT],
			sb.errors);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("page_table_walker_x86_64: match");
		else
			$display("page_table_walker_x86_64: mismatch");
		$finish;
	end

endmodule
